// File: rtl/core/pal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list package
// Sizes, operation and status codes, and the word and control structs shared
// by the list cells, the find scanner and the top level.
// ----------------------------------------------------------------------------
package pal_pkg;

  localparam int CAPACITY = 16;

  localparam int OP_W  = 3;
  localparam int POS_W = 4;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;
  localparam int EC_W  = 5;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GRP    = 2 ** POS_W;
  localparam int NGRP   = (CAPACITY + GRP - 1) / GRP;
  localparam int SCAN_W = NGRP * GRP;
  localparam int GL_W   = $clog2(NGRP + 1);

  typedef logic [OP_W-1:0] op_t;
  typedef logic [ST_W-1:0] status_t;

  localparam op_t OP_INSERT = 3'd0;
  localparam op_t OP_DELETE = 3'd1;
  localparam op_t OP_READ   = 3'd2;
  localparam op_t OP_CLEAR  = 3'd3;
  localparam op_t OP_FIND   = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_BAD      = 2'd2;
  localparam status_t ST_NOTFOUND = 2'd3;

  typedef struct packed {
    op_t                     operation;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    status_t                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [POS_W-1:0]        found_position;
    logic [EC_W-1:0]         entry_count;
    logic                    is_empty;
    logic                    is_full;
  } result_t;

  typedef struct packed {
    logic                    ins;
    logic                    del;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        cnt;
    logic signed [VAL_W-1:0] val;
  } cell_ctrl_t;

  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [POS_W-1:0] fpos;
  } find_res_t;

endpackage
`default_nettype wire

// File: rtl/core/pal_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list cell
// Holds one list entry, takes its neighbor's entry on a shift and flags a
// match against the search value.
// ----------------------------------------------------------------------------
module pal_cell (
  input  wire logic                            clk,
  input  wire logic [pal_pkg::CMP_W-1:0]       index,
  input  wire pal_pkg::cell_ctrl_t             ctrl,
  input  wire logic signed [pal_pkg::VAL_W-1:0] left_val,
  input  wire logic signed [pal_pkg::VAL_W-1:0] right_val,
  output logic signed [pal_pkg::VAL_W-1:0]      val_out,
  output logic                                 hit
);

  logic signed [pal_pkg::VAL_W-1:0] entry;
  logic signed [pal_pkg::VAL_W-1:0] entry_next;

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (index > ctrl.pos) begin
        entry_next = left_val;
      end else if (index == ctrl.pos) begin
        entry_next = ctrl.val;
      end
    end else if (ctrl.del && (index >= ctrl.pos)) begin
      entry_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  assign val_out = entry;
  assign hit     = (index < ctrl.cnt) && (entry == ctrl.val);

endmodule
`default_nettype wire

// File: rtl/core/pal_find.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list find scanner
// Captures the match flags of all cells and walks them one group of sixteen
// per cycle to report the first match.
// ----------------------------------------------------------------------------
module pal_find (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           load,
  input  wire logic [pal_pkg::CAPACITY-1:0]   hits,
  output logic                                active,
  output pal_pkg::find_res_t                  res
);

  logic [pal_pkg::SCAN_W-1:0] scan;
  logic [pal_pkg::GL_W-1:0]   grp_left;
  logic [pal_pkg::GRP-1:0]    low;
  logic [pal_pkg::POS_W-1:0]  enc;

  assign low = scan[pal_pkg::GRP-1:0];

  always_comb begin
    enc = '0;
    for (int i = pal_pkg::GRP - 1; i >= 0; i--) begin
      if (low[i]) begin
        enc = pal_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    res.valid = active && ((|low) || (grp_left == '0));
    res.hit   = |low;
    res.fpos  = (|low) ? enc : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (res.valid) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      scan     <= pal_pkg::SCAN_W'(hits);
      grp_left <= pal_pkg::GL_W'(pal_pkg::NGRP - 1);
    end else if (active) begin
      scan     <= scan >> pal_pkg::GRP;
      grp_left <= grp_left - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/positional_array_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Positional array list
// Ordered list of signed words in a row of cells with insert, delete, read,
// clear and find-first operations.
// ----------------------------------------------------------------------------
//   channel   handshake           word
//   input     start / busy        item   (operation, position, value)
//   output    done                result (status, read value, position, count)
//
// Insert, delete, read, clear and unused codes finish at once: the result
// strobe follows the accepting edge and busy stays low, so items may follow
// back to back. Find holds busy while it walks the cells a group of sixteen
// at a time, up to the first group with a match or the last group, then
// strobes its result. Reset empties the list; entry contents are not cleared.
// The receiver cannot stall, so each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_array_list (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire pal_pkg::item_t  item,
  output logic                 busy,
  output logic                 done,
  output pal_pkg::result_t     result
);

  logic [pal_pkg::CNT_W-1:0]         count;
  logic [pal_pkg::CNT_W-1:0]         count_next;
  logic signed [pal_pkg::VAL_W-1:0]  cell_val [pal_pkg::CAPACITY];
  logic [pal_pkg::CAPACITY-1:0]      cell_hit;
  pal_pkg::cell_ctrl_t               ctrl;
  pal_pkg::find_res_t                fres;
  pal_pkg::result_t                  res_next;
  logic                              find_active;
  logic                              accept;
  logic [pal_pkg::CMP_W-1:0]         pos_w;
  logic [pal_pkg::CMP_W-1:0]         cnt_w;
  logic                              ins_ok;
  logic                              del_ok;
  logic                              rd_ok;
  logic                              is_full_now;

  assign busy   = find_active;
  assign accept = start && !busy;
  assign pos_w  = pal_pkg::CMP_W'(item.position);
  assign cnt_w  = pal_pkg::CMP_W'(count);

  assign is_full_now = (count == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
  assign ins_ok = !is_full_now && (pos_w <= cnt_w);
  assign del_ok = pos_w < cnt_w;
  assign rd_ok  = pos_w < cnt_w;

  always_comb begin
    ctrl.ins = accept && (item.operation == pal_pkg::OP_INSERT) && ins_ok;
    ctrl.del = accept && (item.operation == pal_pkg::OP_DELETE) && del_ok;
    ctrl.pos = pos_w;
    ctrl.cnt = cnt_w;
    ctrl.val = item.value;
  end

  for (genvar i = 0; i < pal_pkg::CAPACITY; i++) begin : g_cell
    logic signed [pal_pkg::VAL_W-1:0] left_val;
    logic signed [pal_pkg::VAL_W-1:0] right_val;
    if (i == 0) begin : g_first
      assign left_val = '0;
    end else begin : g_mid
      assign left_val = cell_val[i-1];
    end
    if (i == pal_pkg::CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end
    pal_cell u_cell (
      .clk       (clk),
      .index     (pal_pkg::CMP_W'(i)),
      .ctrl      (ctrl),
      .left_val  (left_val),
      .right_val (right_val),
      .val_out   (cell_val[i]),
      .hit       (cell_hit[i])
    );
  end

  pal_find u_find (
    .clk    (clk),
    .rst    (rst),
    .load   (accept && (item.operation == pal_pkg::OP_FIND)),
    .hits   (cell_hit),
    .active (find_active),
    .res    (fres)
  );

  always_comb begin
    count_next = count;
    res_next   = '0;
    if (fres.valid) begin
      res_next.status         = fres.hit ? pal_pkg::ST_OK : pal_pkg::ST_NOTFOUND;
      res_next.found_position = fres.fpos;
    end else begin
      case (item.operation)
        pal_pkg::OP_INSERT: begin
          if (is_full_now) begin
            res_next.status = pal_pkg::ST_FULL;
          end else if (!ins_ok) begin
            res_next.status = pal_pkg::ST_BAD;
          end else begin
            count_next = count + 1'b1;
          end
        end
        pal_pkg::OP_DELETE: begin
          if (del_ok) begin
            count_next = count - 1'b1;
          end else begin
            res_next.status = pal_pkg::ST_BAD;
          end
        end
        pal_pkg::OP_READ: begin
          if (rd_ok) begin
            res_next.read_value = cell_val[pos_w[pal_pkg::IDX_W-1:0]];
          end else begin
            res_next.status = pal_pkg::ST_BAD;
          end
        end
        pal_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        default: begin
        end
      endcase
    end
    res_next.entry_count = pal_pkg::EC_W'(count_next);
    res_next.is_empty    = (count_next == '0);
    res_next.is_full     = (count_next == pal_pkg::CNT_W'(pal_pkg::CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= fres.valid || (accept && (item.operation != pal_pkg::OP_FIND));
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
  end

endmodule
`default_nettype wire
